// ===== rtl/sbt_pkg.sv =====
package sbt_pkg;

    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 5;
    localparam int TOTAL_OUT_W = 6;
    localparam int PAGE_W      = 8;
    localparam int PCNT_W      = 6;
    localparam int WORD_W      = 32;

    // Slots keep the low 14 address bits; a match also needs the upper bits zero.
    localparam int SLOT_ADDR_W  = 14;
    localparam int PAGE_ENTRIES = 256;

    localparam logic [PCNT_W-1:0] PCNT_MAX = 6'd63;

    localparam logic [SIZE_W-1:0] BP_SIZE_HALF = 3'd2;
    localparam logic [SIZE_W-1:0] BP_SIZE_FULL = 3'd4;

    localparam logic [WORD_W-1:0] TRAP_HALF = 32'h0000_9002;
    localparam logic [WORD_W-1:0] TRAP_FULL = 32'h0010_0073;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET       = 2'd0,
        KIND_CLEAR     = 2'd1,
        KIND_CLEAR_ALL = 2'd2,
        KIND_LOOKUP    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_ALREADY   = 3'd3,
        ST_NO_SLOT   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PG_NONE = 2'd0,
        PG_INC  = 2'd1,
        PG_DEC  = 2'd2
    } page_op_t;

    // Outcome of the slot stage, carried to the page counter stage.
    typedef struct packed {
        status_t                 status;
        logic [SLOT_OUT_W-1:0]   slot;
        logic                    hit;
        logic [TOTAL_OUT_W-1:0]  total;
        page_op_t                op;
        logic [WORD_W-1:0]       patch_word;
    } slot_res_t;

endpackage

// ===== rtl/sbt_cmd_if.sv =====
interface sbt_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [sbt_pkg::KIND_W-1:0]  kind;
    logic [sbt_pkg::ADDR_W-1:0]  addr;
    logic [sbt_pkg::SIZE_W-1:0]  size;

    modport source (output valid, kind, addr, size, input ready);
    modport sink   (input valid, kind, addr, size, output ready);
endinterface

// ===== rtl/sbt_rsp_if.sv =====
interface sbt_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [sbt_pkg::STATUS_W-1:0]     status;
    logic [sbt_pkg::SLOT_OUT_W-1:0]   slot;
    logic                             hit;
    logic [sbt_pkg::TOTAL_OUT_W-1:0]  total;
    logic [sbt_pkg::PAGE_W-1:0]       page;
    logic [sbt_pkg::PCNT_W-1:0]       page_breaks;
    logic                             first_in_page;
    logic [sbt_pkg::WORD_W-1:0]       patch_word;

    modport source (output valid, status, slot, hit, total, page, page_breaks,
                    first_in_page, patch_word, input ready);
    modport sink   (input valid, status, slot, hit, total, page, page_breaks,
                    first_in_page, patch_word, output ready);
endinterface

// ===== rtl/sbt_ram.sv =====
module sbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sbt_slots.sv =====
module sbt_slots #(
    parameter int SLOTS       = 32,
    parameter int FLASH_BYTES = 16384
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sbt_pkg::KIND_W-1:0]   kind,
    input  logic [sbt_pkg::ADDR_W-1:0]   addr,
    input  logic [sbt_pkg::SIZE_W-1:0]   size,
    input  logic                         commit,
    output sbt_pkg::slot_res_t           res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SAW   = sbt_pkg::SLOT_ADDR_W;
    localparam logic [sbt_pkg::ADDR_W-1:0] LIM_HALF = 32'(FLASH_BYTES - 2);
    localparam logic [sbt_pkg::ADDR_W-1:0] LIM_FULL = 32'(FLASH_BYTES - 4);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [SAW-1:0]   addr_reg [SLOTS];
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;

    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] low_hit;
    logic [SLOTS-1:0] free_vec;
    logic [SLOTS-1:0] low_free;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic             any_hit;
    logic             any_free;
    logic             size_ok;
    logic             addr_ok;
    logic             set_en;
    logic             clr_en;
    logic             clr_all;
    sbt_pkg::slot_res_t res_c;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_vec[i] = valid_reg[i] && (addr[sbt_pkg::ADDR_W-1:SAW] == '0)
                         && (addr[SAW-1:0] == addr_reg[i]);
        end
    end

    // Wide flash sizes can leave the same low bits in two slots; the lowest one wins.
    assign low_hit  = hit_vec & (~hit_vec + SLOTS'(1));
    assign free_vec = ~valid_reg;
    assign low_free = free_vec & (~free_vec + SLOTS'(1));
    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (low_hit[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (low_free[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    assign size_ok = (size == sbt_pkg::BP_SIZE_HALF) || (size == sbt_pkg::BP_SIZE_FULL);
    assign addr_ok = !addr[0] &&
                     ((size == sbt_pkg::BP_SIZE_HALF) ? (addr < LIM_HALF) : (addr < LIM_FULL));

    always_comb
    begin
        res_c.status     = sbt_pkg::ST_OK;
        res_c.slot       = '0;
        res_c.hit        = 1'b0;
        res_c.total      = '0;
        res_c.op         = sbt_pkg::PG_NONE;
        res_c.patch_word = '0;
        set_en           = 1'b0;
        clr_en           = 1'b0;
        clr_all          = 1'b0;
        case (sbt_pkg::kind_t'(kind))
            sbt_pkg::KIND_SET:
            begin
                if (!size_ok)
                    res_c.status = sbt_pkg::ST_BAD_SIZE;
                else if (!addr_ok)
                    res_c.status = sbt_pkg::ST_BAD_ADDR;
                else if (any_hit)
                    res_c.status = sbt_pkg::ST_ALREADY;
                else if (!any_free)
                    res_c.status = sbt_pkg::ST_NO_SLOT;
                else
                begin
                    set_en           = 1'b1;
                    res_c.slot       = sbt_pkg::SLOT_OUT_W'(free_idx);
                    res_c.op         = sbt_pkg::PG_INC;
                    res_c.patch_word = (size == sbt_pkg::BP_SIZE_HALF) ?
                                       sbt_pkg::TRAP_HALF : sbt_pkg::TRAP_FULL;
                end
            end
            sbt_pkg::KIND_CLEAR:
            begin
                if (!size_ok)
                    res_c.status = sbt_pkg::ST_BAD_SIZE;
                else if (!addr_ok)
                    res_c.status = sbt_pkg::ST_BAD_ADDR;
                else if (!any_hit)
                    res_c.status = sbt_pkg::ST_NOT_FOUND;
                else
                begin
                    clr_en     = 1'b1;
                    res_c.slot = sbt_pkg::SLOT_OUT_W'(hit_idx);
                    res_c.op   = sbt_pkg::PG_DEC;
                end
            end
            sbt_pkg::KIND_CLEAR_ALL:
            begin
                clr_all = 1'b1;
            end
            sbt_pkg::KIND_LOOKUP:
            begin
                res_c.hit    = any_hit;
                res_c.status = any_hit ? sbt_pkg::ST_OK : sbt_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                res_c.status = sbt_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        total_next = total_reg;
        if (set_en)
        begin
            valid_next = valid_reg | low_free;
            total_next = total_reg + CNT_W'(1);
        end
        else if (clr_en)
        begin
            valid_next = valid_reg & ~low_hit;
            total_next = (total_reg != '0) ? total_reg - CNT_W'(1) : total_reg;
        end
        else if (clr_all)
        begin
            valid_next = '0;
            total_next = '0;
        end
    end

    always_comb
    begin
        res       = res_c;
        res.total = sbt_pkg::TOTAL_OUT_W'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
        end
        else if (commit)
        begin
            valid_reg <= valid_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (commit && set_en && low_free[i])
            begin
                addr_reg[i] <= addr[SAW-1:0];
            end
        end
    end

    a_total_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == CNT_W'($countones(valid_reg)))
        else $error("held total differs from number of valid slots");

    a_no_duplicate: assert property (@(posedge clk) disable iff (!rst_n)
        (FLASH_BYTES > (1 << SAW)) || $onehot0(hit_vec))
        else $error("address held in more than one slot");

    a_slots_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(valid_reg) && $stable(total_reg))
        else $error("slot table changed without a committed item");

endmodule

// ===== rtl/sbt_page.sv =====
module sbt_page #(
    parameter int PAGE_BYTES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sbt_pkg::ADDR_W-1:0]    addr,
    input  logic                          rd_en,
    output logic [sbt_pkg::PAGE_W-1:0]    page,
    input  logic [sbt_pkg::PAGE_W-1:0]    upd_page,
    input  sbt_pkg::page_op_t             upd_op,
    input  logic                          upd_en,
    output logic [sbt_pkg::PCNT_W-1:0]    count
);

    // page = addr / PAGE_BYTES by exact reciprocal: ceil(2^(32+L) / PAGE_BYTES)
    localparam int L     = $clog2(PAGE_BYTES);
    localparam int SHIFT = sbt_pkg::ADDR_W + L;
    localparam int RW    = sbt_pkg::ADDR_W + 2;
    localparam int PW    = sbt_pkg::ADDR_W + RW;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];
    localparam int PN = sbt_pkg::PAGE_ENTRIES;

    logic [PW-1:0]                 prod;
    logic [PN-1:0]                 pvalid_reg;
    logic                          pv_rd_reg;
    logic                          fwd_hit_reg;
    logic [sbt_pkg::PCNT_W-1:0]    fwd_data_reg;
    logic [sbt_pkg::PCNT_W-1:0]    ram_q;
    logic [sbt_pkg::PCNT_W-1:0]    cur;
    logic                          wr_en;

    assign prod = {{RW{1'b0}}, addr} * {{sbt_pkg::ADDR_W{1'b0}}, RECIP};
    assign page = prod[SHIFT +: sbt_pkg::PAGE_W];

    sbt_ram #(
        .WIDTH (sbt_pkg::PCNT_W),
        .DEPTH (PN)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (upd_page),
        .wdata (count),
        .re    (rd_en),
        .raddr (page),
        .rdata (ram_q)
    );

    // A write in the same cycle as the read is not seen by the RAM; forward it.
    assign cur = fwd_hit_reg ? fwd_data_reg : (pv_rd_reg ? ram_q : '0);

    always_comb
    begin
        case (upd_op)
            sbt_pkg::PG_INC:
                count = (cur == sbt_pkg::PCNT_MAX) ? cur : cur + sbt_pkg::PCNT_W'(1);
            sbt_pkg::PG_DEC:
                count = (cur == '0) ? cur : cur - sbt_pkg::PCNT_W'(1);
            default:
                count = cur;
        endcase
    end

    assign wr_en = upd_en && (upd_op != sbt_pkg::PG_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg  <= '0;
            pv_rd_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                pvalid_reg[upd_page] <= 1'b1;
            end
            if (rd_en)
            begin
                pv_rd_reg   <= pvalid_reg[page];
                fwd_hit_reg <= wr_en && (upd_page == page);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= count;
        end
    end

endmodule

// ===== rtl/soft_breakpoint_table.sv =====
// Software breakpoint slot table. Each command transfer (set, clear, clear all,
// lookup) yields exactly one response transfer, in order. The block is a
// three-stage pipeline: the input register feeds the slot match, lowest-free
// slot pick and the page index (a reciprocal multiply); the second stage does
// the read-modify-write of the per-page breakpoint count held in a 256-entry
// RAM, with the previous write forwarded; the third is the output register.
// A command passes through the input register, the second stage and the
// output register in turn before its response is valid. One command is
// taken every cycle while the response side keeps up; a stalled response
// backs up the three registers and then drops the command ready. Page counts
// start at zero after reset by way of a valid bit per page, so no clearing
// pass is needed and commands are taken right after reset.
module soft_breakpoint_table #(
    parameter int SLOTS       = 32,
    parameter int PAGE_BYTES  = 64,
    parameter int FLASH_BYTES = 16384
) (
    input  logic       clk,
    input  logic       rst_n,
    sbt_cmd_if.sink    cmd,
    sbt_rsp_if.source  rsp
);

    logic                          s1_v_reg;
    logic [sbt_pkg::KIND_W-1:0]    s1_kind_reg;
    logic [sbt_pkg::ADDR_W-1:0]    s1_addr_reg;
    logic [sbt_pkg::SIZE_W-1:0]    s1_size_reg;

    logic                          s2_v_reg;
    sbt_pkg::slot_res_t            s2_res_reg;
    logic [sbt_pkg::PAGE_W-1:0]    s2_page_reg;

    logic                          out_v_reg;
    sbt_pkg::status_t              out_status_reg;
    logic [sbt_pkg::SLOT_OUT_W-1:0]  out_slot_reg;
    logic                          out_hit_reg;
    logic [sbt_pkg::TOTAL_OUT_W-1:0] out_total_reg;
    logic [sbt_pkg::PAGE_W-1:0]    out_page_reg;
    logic [sbt_pkg::PCNT_W-1:0]    out_pbreaks_reg;
    logic                          out_first_reg;
    logic [sbt_pkg::WORD_W-1:0]    out_patch_reg;

    logic                          s2_go;
    logic                          s2_adv;
    logic                          s1_go;
    logic                          s1_adv;
    logic                          in_rdy;
    sbt_pkg::slot_res_t            s1_res;
    logic [sbt_pkg::PAGE_W-1:0]    s1_page;
    logic [sbt_pkg::PCNT_W-1:0]    s2_count;

    assign s2_go  = !out_v_reg || rsp.ready;
    assign s2_adv = s2_v_reg && s2_go;
    assign s1_go  = !s2_v_reg || s2_go;
    assign s1_adv = s1_v_reg && s1_go;
    assign in_rdy = !s1_v_reg || s1_go;

    assign cmd.ready = in_rdy;

    sbt_slots #(
        .SLOTS       (SLOTS),
        .FLASH_BYTES (FLASH_BYTES)
    ) u_slots (
        .clk    (clk),
        .rst_n  (rst_n),
        .kind   (s1_kind_reg),
        .addr   (s1_addr_reg),
        .size   (s1_size_reg),
        .commit (s1_adv),
        .res    (s1_res)
    );

    sbt_page #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (s1_addr_reg),
        .rd_en    (s1_adv),
        .page     (s1_page),
        .upd_page (s2_page_reg),
        .upd_op   (s2_res_reg.op),
        .upd_en   (s2_adv),
        .count    (s2_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_rdy)
            begin
                s1_v_reg <= cmd.valid;
            end
            if (s1_go)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s2_go)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && cmd.valid)
        begin
            s1_kind_reg <= cmd.kind;
            s1_addr_reg <= cmd.addr;
            s1_size_reg <= cmd.size;
        end
        if (s1_adv)
        begin
            s2_res_reg  <= s1_res;
            s2_page_reg <= s1_page;
        end
        if (s2_adv)
        begin
            out_status_reg  <= s2_res_reg.status;
            out_slot_reg    <= s2_res_reg.slot;
            out_hit_reg     <= s2_res_reg.hit;
            out_total_reg   <= s2_res_reg.total;
            out_page_reg    <= s2_page_reg;
            out_pbreaks_reg <= s2_count;
            out_first_reg   <= (s2_res_reg.op == sbt_pkg::PG_INC) &&
                               (s2_count == sbt_pkg::PCNT_W'(1));
            out_patch_reg   <= s2_res_reg.patch_word;
        end
    end

    assign rsp.valid         = out_v_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.total         = out_total_reg;
    assign rsp.page          = out_page_reg;
    assign rsp.page_breaks   = out_pbreaks_reg;
    assign rsp.first_in_page = out_first_reg;
    assign rsp.patch_word    = out_patch_reg;

    a_first_means_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_first_reg |-> out_pbreaks_reg == sbt_pkg::PCNT_W'(1))
        else $error("first breakpoint in page reported with page count not one");

    a_fail_no_patch: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && (out_status_reg != sbt_pkg::ST_OK)
        |-> (out_patch_reg == '0) && !out_first_reg)
        else $error("failed command carries a trap word or first-in-page flag");

    a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_hit_reg |-> out_status_reg == sbt_pkg::ST_OK)
        else $error("lookup hit reported with non-ok status");

endmodule
